### src/kilt_pkg.sv
// ----------------------------------------------------------------------------
// kilt_pkg: key table shared definitions
// Sizes, operation codes and the token type that runs down the cell chain.
// ----------------------------------------------------------------------------
package kilt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_W       = 32;
   localparam int POS_W       = 9;
   localparam int OP_W        = 2;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic             hit;
      logic [POS_W-1:0] pos;
   } token_type;

   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] key;
   } load_type;

endpackage

### src/kilt_req_if.sv
// ----------------------------------------------------------------------------
// kilt_req_if: request channel
// Valid/ready channel carrying one operation and its key.
// ----------------------------------------------------------------------------
interface kilt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] key_word;

   modport source (output valid, operation, key_word, input ready);
   modport sink   (input valid, operation, key_word, output ready);
endinterface

### src/kilt_rsp_if.sv
// ----------------------------------------------------------------------------
// kilt_rsp_if: response channel
// Valid/ready channel carrying one lookup result.
// ----------------------------------------------------------------------------
interface kilt_rsp_if;
   logic              valid;
   logic              ready;
   logic              hit;
   logic signed [8:0] found_position;
   logic              overflowed;

   modport source (output valid, hit, found_position, overflowed, input ready);
   modport sink   (input valid, hit, found_position, overflowed, output ready);
endinterface

### src/key_to_index_lookup_table_unit.sv
// ----------------------------------------------------------------------------
// key_to_index_lookup_table_unit: key to position lookup table
// Loads keys at successive positions and looks up the latest position of a key.
// Clear and load may follow back to back.
// A lookup walks the chain of TABLE_DEPTH cells, one cell per cycle, and its
// result is registered at the response output. One lookup is in flight at a
// time: no new request is taken until it has left the end of the chain.
// Reset empties the table and clears the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module key_to_index_lookup_table_unit (
   input  logic       clock,
   input  logic       reset,
   kilt_req_if.sink   req_if,
   kilt_rsp_if.source rsp_if
);
   import kilt_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic             busy_ff;
   logic             busy_in;
   logic             accept;
   logic             rsp_free;

   token_type        link [TABLE_DEPTH+1];
   load_type         load;

   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_ovf_ff;
   logic             pend_valid_ff;
   logic             pend_hit_ff;
   logic [POS_W-1:0] pend_pos_ff;
   logic             pend_ovf_ff;

   assign req_if.ready = !busy_ff && !pend_valid_ff;
   assign accept       = req_if.valid && req_if.ready;

   assign load.en  = accept && (req_if.operation == OP_LOAD);
   assign load.key = req_if.key_word;

   assign link[0].valid = accept && (req_if.operation == OP_LOOKUP);
   assign link[0].key   = req_if.key_word;
   assign link[0].hit   = 1'b0;
   assign link[0].pos   = '1;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      kilt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CNT_W'(i)),
         .count      (count_ff),
         .load       (load),
         .prev_tok   (link[i]),
         .next_tok   (link[i+1])
      );
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         unique case (req_if.operation)
            OP_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
            end
            OP_LOAD: begin
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (link[0].valid) begin
         busy_in = 1'b1;
      end else if (link[TABLE_DEPTH].valid) begin
         busy_in = 1'b0;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         busy_ff     <= busy_in;
         if (rsp_free) begin
            if (pend_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               pend_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= link[TABLE_DEPTH].valid;
            end
         end else if (link[TABLE_DEPTH].valid) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (pend_valid_ff) begin
            rsp_hit_ff <= pend_hit_ff;
            rsp_pos_ff <= pend_pos_ff;
            rsp_ovf_ff <= pend_ovf_ff;
         end else if (link[TABLE_DEPTH].valid) begin
            rsp_hit_ff <= link[TABLE_DEPTH].hit;
            rsp_pos_ff <= link[TABLE_DEPTH].pos;
            rsp_ovf_ff <= overflow_ff;
         end
      end else if (link[TABLE_DEPTH].valid) begin
         pend_hit_ff <= link[TABLE_DEPTH].hit;
         pend_pos_ff <= link[TABLE_DEPTH].pos;
         pend_ovf_ff <= overflow_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.hit            = rsp_hit_ff;
   assign rsp_if.found_position = rsp_pos_ff;
   assign rsp_if.overflowed     = rsp_ovf_ff;

endmodule

### src/kilt_cell.sv
// ----------------------------------------------------------------------------
// kilt_cell: one table position
// Holds one key, compares a passing lookup token and hands it on.
// ----------------------------------------------------------------------------
module kilt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [kilt_pkg::CNT_W-1:0] cell_index,
   input  logic [kilt_pkg::CNT_W-1:0] count,
   input  kilt_pkg::load_type        load,
   input  kilt_pkg::token_type       prev_tok,
   output kilt_pkg::token_type       next_tok
);
   import kilt_pkg::*;

   logic [KEY_W-1:0] key_ff;
   token_type        tok_in;
   token_type        tok_ff;

   always_ff @(posedge clock) begin
      if (load.en && (count == cell_index)) begin
         key_ff <= load.key;
      end
   end

   always_comb begin
      tok_in = prev_tok;
      if (prev_tok.valid && (cell_index < count) && (key_ff == prev_tok.key)) begin
         tok_in.hit = 1'b1;
         tok_in.pos = POS_W'(cell_index);
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end
   end

   assign next_tok = tok_ff;

endmodule

### sim/tb_key_to_index_lookup_table_unit.sv
// ----------------------------------------------------------------------------
// tb_key_to_index_lookup_table_unit: key table lookup testbench
// Drives clear, load and lookup operations through the request channel and
// checks every lookup response against a local model of the key table. It
// covers directed corner cases, a full table with dropped loads, a long
// response stall and a long random run.
// ----------------------------------------------------------------------------
module tb_key_to_index_lookup_table_unit;
   import kilt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 1800;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;
   localparam int PRINT_LIMIT    = 30;

   typedef struct {
      logic                    hit;
      logic signed [POS_W-1:0] found_position;
      logic                    overflowed;
   } lookup_result_type;

   logic clock;
   logic reset;

   kilt_req_if req_if();
   kilt_rsp_if rsp_if();

   key_to_index_lookup_table_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // key table model
   logic signed [KEY_W-1:0] model_keys [TABLE_DEPTH];
   int                      model_count;
   logic                    model_overflow;
   lookup_result_type       lookup_expect_q [$];

   bit req_idle_en;
   bit rsp_idle_en;
   int rsp_hold_left;
   int idle_cycles;

   int n_items;
   int n_lookups;
   int n_hits;
   int n_ovf_lookups;
   int n_checked;
   int n_errors;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(KEY_W-1){1'b0}}};
         1:       return {1'b0, {(KEY_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // biased toward keys already held, so duplicates and hits are common
   function automatic logic signed [KEY_W-1:0] held_key(int pct);
      if (model_count > 0 && $urandom_range(0, 99) < pct)
         return model_keys[$urandom_range(0, model_count - 1)];
      return random_key();
   endfunction

   function automatic void table_model_apply(logic [OP_W-1:0] op,
                                             logic signed [KEY_W-1:0] key);
      lookup_result_type r;
      int                pos;
      case (op)
         OP_CLEAR: begin
            model_count    = 0;
            model_overflow = 1'b0;
         end
         OP_LOAD: begin
            if (model_count < TABLE_DEPTH) begin
               model_keys[model_count] = key;
               model_count++;
            end else begin
               model_overflow = 1'b1;
            end
         end
         OP_LOOKUP: begin
            pos = -1;
            for (int i = model_count - 1; i >= 0 && pos < 0; i--)
               if (model_keys[i] == key) pos = i;
            r.hit            = (pos >= 0);
            r.found_position = pos[POS_W-1:0];
            r.overflowed     = model_overflow;
            lookup_expect_q.push_back(r);
            n_lookups++;
            if (r.hit) n_hits++;
            if (r.overflowed) n_ovf_lookups++;
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= PRINT_LIMIT)
         $display("tb: mismatch at %0t: %s", $time, msg);
   endtask

   // entered and left right after a rising edge
   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
      int gap;
      gap = req_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.key_word  <= key;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      table_model_apply(op, key);
      if (op != OP_UNUSED) n_items++;
   endtask

   task automatic wait_all_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (lookup_expect_q.size() != 0);
   endtask

   task automatic test_directed();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_item(OP_CLEAR, '0);
      send_item(OP_LOOKUP, '0);
      send_item(OP_LOAD, 32'sh8000_0000);
      send_item(OP_LOAD, 32'sh7FFF_FFFF);
      send_item(OP_LOAD, 32'sh0000_0000);
      send_item(OP_LOAD, -32'sd1);
      send_item(OP_LOAD, 32'sh5A5A_5A5A);
      send_item(OP_LOAD, 32'sh0000_0000);
      send_item(OP_LOOKUP, 32'sh8000_0000);
      send_item(OP_LOOKUP, 32'sh7FFF_FFFF);
      send_item(OP_LOOKUP, 32'sh0000_0000);
      send_item(OP_LOOKUP, -32'sd1);
      send_item(OP_LOOKUP, 32'sh1234_5678);
      send_item(OP_UNUSED, 32'sh0000_0000);
      send_item(OP_LOOKUP, 32'sh0000_0000);
      send_item(OP_CLEAR, -32'sd1);
      send_item(OP_LOOKUP, 32'sh7FFF_FFFF);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   task automatic test_table_full();
      logic signed [KEY_W-1:0] first_key;
      logic signed [KEY_W-1:0] last_key;
      logic signed [KEY_W-1:0] extra_key;
      req_idle_en = 1'b0;
      send_item(OP_CLEAR, '0);
      for (int i = 0; i < TABLE_DEPTH; i++) send_item(OP_LOAD, held_key(10));
      first_key = model_keys[0];
      last_key  = model_keys[TABLE_DEPTH-1];
      extra_key = random_key();
      send_item(OP_LOOKUP, first_key);
      send_item(OP_LOOKUP, last_key);
      send_item(OP_LOAD, extra_key);
      send_item(OP_LOAD, extra_key);
      send_item(OP_LOOKUP, extra_key);
      send_item(OP_LOOKUP, last_key);
      send_item(OP_UNUSED, extra_key);
      send_item(OP_LOOKUP, first_key);
      send_item(OP_CLEAR, '0);
      send_item(OP_LOOKUP, first_key);
      req_idle_en = 1'b1;
   endtask

   task automatic test_rsp_stall();
      req_idle_en   = 1'b0;
      rsp_hold_left = 800;
      send_item(OP_CLEAR, '0);
      for (int i = 0; i < 6; i++) begin
         send_item(OP_LOAD, random_key());
         send_item(OP_LOOKUP, held_key(70));
         send_item(OP_LOAD, held_key(40));
      end
      req_idle_en = 1'b1;
   endtask

   task automatic test_random();
      int sel;
      int n_load;
      int iter;
      iter = 0;
      while (n_items < ITEM_TARGET) begin
         if (iter % 40 == 0) begin
            req_idle_en = ($urandom_range(0, 3) != 0);
            rsp_idle_en = ($urandom_range(0, 3) != 0);
         end
         iter++;
         sel = $urandom_range(0, 99);
         if (sel < 8) send_item(OP_CLEAR, random_key());
         else if (sel < 11) send_item(OP_UNUSED, random_key());
         n_load = $urandom_range(0, (sel % 5 == 0) ? 90 : 12);
         for (int i = 0; i < n_load; i++) send_item(OP_LOAD, held_key(30));
         repeat ($urandom_range(1, 3)) send_item(OP_LOOKUP, held_key(65));
         if ($urandom_range(0, 19) == 0) wait_all_results();
      end
   endtask

   initial begin : rsp_ready_drive
      int stall_left;
      stall_left    = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!rsp_idle_en) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         n_checked++;
         if (lookup_expect_q.size() == 0) begin
            report_mismatch("response transfer with no lookup pending");
         end else begin
            want = lookup_expect_q.pop_front();
            if (rsp_if.hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", rsp_if.hit, want.hit));
            if (rsp_if.found_position !== want.found_position)
               report_mismatch($sformatf("found_position %0d, expected %0d",
                                         rsp_if.found_position, want.found_position));
            if (rsp_if.overflowed !== want.overflowed)
               report_mismatch($sformatf("overflowed %b, expected %b",
                                         rsp_if.overflowed, want.overflowed));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_CLEAR;
      req_if.key_word  = '0;
      req_idle_en      = 1'b1;
      rsp_idle_en      = 1'b1;
      rsp_hold_left    = 0;
      idle_cycles      = 0;
      model_count      = 0;
      model_overflow   = 1'b0;
      n_items          = 0;
      n_lookups        = 0;
      n_hits           = 0;
      n_ovf_lookups    = 0;
      n_checked        = 0;
      n_errors         = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      wait_all_results();
      test_table_full();
      wait_all_results();
      test_rsp_stall();
      wait_all_results();
      test_random();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d transfers in, %0d lookups: %0d hits, %0d with overflow set",
               n_items, n_lookups, n_hits, n_ovf_lookups);
      $display("tb: %0d responses checked, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0 && lookup_expect_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
